### sv/srpc_pkg.sv
`timescale 1ns / 1ps

package srpc_pkg;

   // Parser phases
   typedef enum logic [2:0] {
      PH_OPEN   = 3'd0,
      PH_FIRST  = 3'd1,
      PH_RHOST  = 3'd2,
      PH_RCOMMA = 3'd3,
      PH_LOCAL  = 3'd4,
      PH_DSTART = 3'd5,
      PH_DOM    = 3'd6
   } phase_type;

   // Status codes
   localparam logic [3:0] ST_PENDING    = 4'd0;
   localparam logic [3:0] ST_PATH_OK    = 4'd1;
   localparam logic [3:0] ST_NULL_PATH  = 4'd2;
   localparam logic [3:0] ST_QUOTED     = 4'd3;
   localparam logic [3:0] ST_NO_OPEN    = 4'd4;
   localparam logic [3:0] ST_NO_COLON   = 4'd5;
   localparam logic [3:0] ST_NO_AT      = 4'd6;
   localparam logic [3:0] ST_NO_DOMAIN  = 4'd7;
   localparam logic [3:0] ST_BAD_DOMAIN = 4'd8;
   localparam logic [3:0] ST_NO_CLOSE   = 4'd9;

   // Characters
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_AT    = 8'h40;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_DASH  = 8'h2D;

   typedef struct packed {
      phase_type  phase;
      logic [7:0] length;
      logic       settled;
      logic [3:0] held;
   } parse_state_type;

   typedef struct packed {
      logic [3:0] status;
      logic       verdict_now;
      logic [7:0] path_length;
   } result_type;

   localparam parse_state_type RESET_STATE = '{
      phase:   PH_OPEN,
      length:  8'd0,
      settled: 1'b0,
      held:    ST_PENDING
   };

   function automatic logic is_alnum(logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_atext(logic [7:0] c);
      return is_alnum(c) || c == 8'h21 || (c >= 8'h23 && c <= 8'h27) ||
             c == 8'h2A || c == 8'h2B || c == CH_DASH || c == 8'h2F ||
             c == 8'h3D || c == 8'h3F || (c >= 8'h5E && c <= 8'h60) ||
             (c >= 8'h7B && c <= 8'h7E);
   endfunction

   function automatic logic is_host(logic [7:0] c);
      return is_alnum(c) || c == CH_DASH || c == CH_DOT;
   endfunction

   // One parser step on one character
   function automatic parse_state_type feed_char(parse_state_type s, logic [7:0] c,
                                                 logic [7:0] limit);
      parse_state_type n;
      logic            take;
      phase_type       nxt;
      logic            stop;
      logic [3:0]      code;
      n    = s;
      take = 1'b0;
      nxt  = s.phase;
      stop = 1'b0;
      code = ST_PENDING;
      case (s.phase)
         PH_FIRST: begin
            if (c == CH_GT) begin
               n.length = 8'd0;
               stop     = 1'b1;
               code     = ST_NULL_PATH;
            end else if (c == CH_QUOTE) begin
               stop = 1'b1;
               code = ST_QUOTED;
            end else if (c == CH_AT) begin
               take = 1'b1;
               nxt  = PH_RHOST;
            end else if (is_atext(c)) begin
               take = 1'b1;
               nxt  = PH_LOCAL;
            end else begin
               stop = 1'b1;
               code = ST_NO_AT;
            end
         end
         PH_RHOST: begin
            if (is_host(c)) begin
               take = 1'b1;
               nxt  = PH_RHOST;
            end else if (c == CH_COMMA) begin
               take = 1'b1;
               nxt  = PH_RCOMMA;
            end else if (c == CH_COLON) begin
               take = 1'b1;
               nxt  = PH_LOCAL;
            end else begin
               stop = 1'b1;
               code = ST_NO_COLON;
            end
         end
         PH_RCOMMA: begin
            if (c == CH_AT) begin
               take = 1'b1;
               nxt  = PH_RHOST;
            end else begin
               stop = 1'b1;
               code = ST_NO_COLON;
            end
         end
         PH_LOCAL: begin
            if (c == CH_AT) begin
               take = 1'b1;
               nxt  = PH_DSTART;
            end else if (is_atext(c)) begin
               take = 1'b1;
               nxt  = PH_LOCAL;
            end else begin
               stop = 1'b1;
               code = ST_NO_AT;
            end
         end
         PH_DSTART: begin
            if (c == CH_NUL) begin
               stop = 1'b1;
               code = ST_NO_DOMAIN;
            end else if (is_alnum(c)) begin
               take = 1'b1;
               nxt  = PH_DOM;
            end else begin
               stop = 1'b1;
               code = ST_BAD_DOMAIN;
            end
         end
         PH_DOM: begin
            if (is_host(c)) begin
               take = 1'b1;
               nxt  = PH_DOM;
            end else if (c == CH_GT) begin
               stop = 1'b1;
               code = ST_PATH_OK;
            end else begin
               stop = 1'b1;
               code = ST_NO_CLOSE;
            end
         end
         default: begin
            if (c == CH_LT) begin
               n.phase = PH_FIRST;
            end else begin
               stop = 1'b1;
               code = ST_NO_OPEN;
            end
         end
      endcase
      if (take) begin
         n.phase = nxt;
         if (s.length < limit) begin
            n.length = s.length + 8'd1;
         end
      end
      if (stop) begin
         n.settled = 1'b1;
         n.held    = code;
      end
      return n;
   endfunction

endpackage

### sv/srpc_channels.sv
`timescale 1ns / 1ps

interface srpc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       last_byte;

   modport source (output valid, output char_in, output last_byte, input ready);
   modport sink (input valid, input char_in, input last_byte, output ready);
endinterface

interface srpc_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] status;
   logic       verdict_now;
   logic [7:0] path_length;

   modport source (output valid, output status, output verdict_now, output path_length,
                   input ready);
   modport sink (input valid, input status, input verdict_now, input path_length,
                 output ready);
endinterface

### sv/srpc_step.sv
`timescale 1ns / 1ps

module srpc_step (
   input  srpc_pkg::parse_state_type state_cur,
   input  logic [7:0]                char_in,
   input  logic                      last_byte,
   input  logic [7:0]                len_limit,
   output srpc_pkg::parse_state_type state_nxt,
   output srpc_pkg::result_type      result
);

   srpc_pkg::parse_state_type after_char;
   srpc_pkg::parse_state_type after_end;

   // Feed the byte, then an end of string on the last byte if still open
   always_comb begin
      after_char = state_cur.settled ? state_cur
                                     : srpc_pkg::feed_char(state_cur, char_in, len_limit);
      after_end  = (!after_char.settled && last_byte)
                 ? srpc_pkg::feed_char(after_char, srpc_pkg::CH_NUL, len_limit)
                 : after_char;
   end

   always_comb begin
      if (after_end.settled) begin
         result.status      = after_end.held;
         result.verdict_now = !state_cur.settled;
         result.path_length = (after_end.held == srpc_pkg::ST_PATH_OK) ? after_end.length
                                                                       : 8'd0;
      end else begin
         result.status      = srpc_pkg::ST_PENDING;
         result.verdict_now = 1'b0;
         result.path_length = 8'd0;
      end
      state_nxt = last_byte ? srpc_pkg::RESET_STATE : after_end;
   end

endmodule

### sv/smtp_reverse_path_checker.sv
`timescale 1ns / 1ps

// Channel    Dir  Payload                              Handshake
// req_chan   in   char_in[7:0], last_byte              valid / ready
// rsp_chan   out  status[3:0], verdict_now, path_length[7:0]  valid / ready
//
// One request per cycle unless the result stalls, one result per request,
// via the input register, then the parse step into the result register.
// The parse step is one pass through the character classifier and the phase
// table, applied twice on a last byte that leaves the verdict open.
// Synchronous active-high reset clears the parser state and both valid flags.
// A stalled result holds; the input register keeps taking a request while the
// result register drains.

module smtp_reverse_path_checker #(
   parameter int unsigned MAX_PATH_LEN = 255
) (
   input logic           clock,
   input logic           reset,
   srpc_req_if.sink      req_chan,
   srpc_rsp_if.source    rsp_chan
);

   // Length count saturates at the smaller of the limit and the 8-bit field
   localparam int unsigned LEN_LIMIT = (MAX_PATH_LEN < 255) ? MAX_PATH_LEN : 255;
   localparam logic [7:0]  LEN_LIMIT_B = LEN_LIMIT[7:0];

   // Input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff, in_char_in;
   logic       in_last_ff, in_last_in;

   // Parser state and result register
   srpc_pkg::parse_state_type state_ff, state_in;
   srpc_pkg::parse_state_type state_step;
   srpc_pkg::result_type      out_ff, out_in;
   srpc_pkg::result_type      result_step;
   logic                      out_valid_ff, out_valid_in;

   logic req_take;
   logic out_free;
   logic step_go;

   // Advance the step when the result register is empty or being drained
   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign step_go  = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || step_go;
   assign req_take = req_chan.valid && req_chan.ready;

   srpc_step u_step (
      .state_cur (state_ff),
      .char_in   (in_char_ff),
      .last_byte (in_last_ff),
      .len_limit (LEN_LIMIT_B),
      .state_nxt (state_step),
      .result    (result_step)
   );

   always_comb begin
      // Load a new request, otherwise drop the one just consumed
      in_valid_in = req_take ? 1'b1 : (step_go ? 1'b0 : in_valid_ff);
      in_char_in  = req_take ? req_chan.char_in : in_char_ff;
      in_last_in  = req_take ? req_chan.last_byte : in_last_ff;

      // Commit parser state only when the result moves forward
      state_in     = step_go ? state_step : state_ff;
      out_in       = step_go ? result_step : out_ff;
      out_valid_in = step_go ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= srpc_pkg::RESET_STATE;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
      in_char_ff <= in_char_in;
      in_last_ff <= in_last_in;
      out_ff     <= out_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.status      = out_ff.status;
   assign rsp_chan.verdict_now = out_ff.verdict_now;
   assign rsp_chan.path_length = out_ff.path_length;

`ifndef SYNTHESIS
   // A fresh verdict always carries a settled status
   a_verdict_has_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.verdict_now) |-> (rsp_chan.status != srpc_pkg::ST_PENDING))
      else $error("verdict without status");

   // A length is reported only with an accepted path
   a_length_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.path_length != 8'd0)
         |-> (rsp_chan.status == srpc_pkg::ST_PATH_OK))
      else $error("length with non-ok status");

   // A settled verdict sticks until the last byte is consumed
   a_settled_sticks: assert property (@(posedge clock) disable iff (reset)
      (state_ff.settled && !(step_go && in_last_ff)) |=> state_ff.settled)
      else $error("verdict lost before last byte");

   // The length count never passes its limit
   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.length <= LEN_LIMIT_B)
      else $error("length count over limit");
`endif

endmodule
